// ===== rtl/core/ievr_pkg.sv =====
// Package for the input event ring with filtered flush.
// Holds event codes, capacities, the operation kinds and the controller/datapath structs.
// Depends on nothing; ievr_ctrl, ievr_dp, the top level and the testbench import it.
`default_nettype none

package ievr_pkg;

    // Default number of slots in the ring.
    localparam int DEPTH_DEFAULT = 16;

    // Event codes, compared as 16-bit patterns.
    localparam logic [15:0] CODE_MOVE = 16'h0004;
    localparam logic [15:0] CODE_HI_A = 16'h0040;
    localparam logic [15:0] CODE_HI_B = 16'h0060;
    localparam logic [15:0] CODE_EDGE = 16'h0002;
    localparam logic [15:0] CODE_KEY  = 16'h0020;

    // Admission capacities for queued events.
    localparam logic [7:0] CAP_HIGH = 8'd9;
    localparam logic [7:0] CAP_LOW  = 8'd7;

    // Largest entry count before saturation.
    localparam logic [7:0] COUNT_MAX = 8'hFF;

    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_QUEUE = 2'd1,
        KIND_KEY   = 2'd2,
        KIND_FLUSH = 2'd3
    } kind_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic exec_op;
        logic flush_init;
        logic walk_step;
        logic copy_step;
        logic flush_finish;
    } ctl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic item_flush;
        logic out_free;
        logic walk_done;
        logic copy_done;
    } ctl_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/ievr_if.sv =====
// Handshake channels of the input event ring: the event word and the result word.
// Each carries valid, ready and the payload; depends on nothing.
`default_nettype none

interface ievr_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic [7:0]         slot_index;
    logic signed [15:0] x_value;
    logic signed [15:0] y_value;
    logic signed [15:0] event_code;

    modport source (output valid, kind, slot_index, x_value, y_value, event_code,
                    input ready);
    modport sink (input valid, kind, slot_index, x_value, y_value, event_code,
                  output ready);
endinterface

interface ievr_out_if;
    logic       valid;
    logic       ready;
    logic       accepted;
    logic [5:0] stored_slot;
    logic [7:0] entry_count;

    modport source (output valid, accepted, stored_slot, entry_count, input ready);
    modport sink (input valid, accepted, stored_slot, entry_count, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/ievr_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`default_nettype none

module ievr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/ievr_ctrl.sv =====
// Controller of the input event ring: sequences inserts and the flush walk and copy.
// Depends on ievr_pkg for the command and status structs.
`default_nettype none

module ievr_ctrl
    import ievr_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire ctl_stat_t stat,
    output ctl_cmd_t       cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_WALK,
        S_COPY,
        S_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   in_ready_reg, in_ready_next;

    assign in_ready = in_ready_reg;

    always_comb
    begin
        cmd           = '0;
        state_next    = state_reg;
        in_ready_next = in_ready_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready_reg)
                begin
                    cmd.capture   = 1'b1;
                    state_next    = S_EXEC;
                    in_ready_next = 1'b0;
                end
            end
            S_EXEC:
            begin
                if (stat.item_flush)
                begin
                    cmd.flush_init = 1'b1;
                    state_next     = S_WALK;
                end
                else if (stat.out_free)
                begin
                    cmd.exec_op   = 1'b1;
                    state_next    = S_IDLE;
                    in_ready_next = 1'b1;
                end
            end
            S_WALK:
            begin
                if (stat.walk_done)
                begin
                    state_next = S_COPY;
                end
                else
                begin
                    cmd.walk_step = 1'b1;
                end
            end
            S_COPY:
            begin
                if (stat.copy_done)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.copy_step = 1'b1;
                end
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.flush_finish = 1'b1;
                    state_next       = S_IDLE;
                    in_ready_next    = 1'b1;
                end
            end
            default:
            begin
                state_next    = S_IDLE;
                in_ready_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            in_ready_reg <= 1'b1;
        end
        else
        begin
            state_reg    <= state_next;
            in_ready_reg <= in_ready_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/ievr_dp.sv =====
// Datapath of the input event ring: ring memories, valid bits, counters,
// the flush scratch buffer and the result register.
// Depends on ievr_pkg and ievr_ram.
`default_nettype none

module ievr_dp
    import ievr_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEPTH_DEFAULT
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire ctl_cmd_t           cmd,
    output ctl_stat_t               stat,
    input  wire logic [1:0]         kind,
    input  wire logic [7:0]         slot_index,
    input  wire logic signed [15:0] x_value,
    input  wire logic signed [15:0] y_value,
    input  wire logic signed [15:0] event_code,
    ievr_out_if.source              results
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C  = CW'(QUEUE_DEPTH);
    localparam logic [AW-1:0] LAST_C   = AW'(QUEUE_DEPTH - 1);
    localparam logic [7:0]    DEPTH_B  = 8'(QUEUE_DEPTH);
    localparam logic [AW:0]   DEPTH_AX = (AW+1)'(QUEUE_DEPTH);

    // Captured item.
    kind_t       item_kind_reg;
    logic [7:0]  item_slot_reg;
    logic [15:0] item_x_reg;
    logic [15:0] item_y_reg;
    logic [15:0] item_code_reg;

    // Ring state.
    logic [AW-1:0]          wp_reg;
    logic [7:0]             count_reg;
    logic [AW-1:0]          cnt_mod_reg;
    logic                   edge_reg;
    logic [QUEUE_DEPTH-1:0] vld_xc_reg;
    logic [QUEUE_DEPTH-1:0] vld_y_reg;

    // Flush sequencing.
    logic [AW-1:0] walk_pos_reg;
    logic [CW-1:0] walk_i_reg;
    logic [CW-1:0] kept_reg;
    logic [CW-1:0] copy_j_reg;
    logic          walk_pend_reg;
    logic          copy_pend_reg;
    logic [AW-1:0] copy_addr_reg;
    logic          vld_xc_q_reg;
    logic          vld_y_q_reg;

    // Result register.
    logic       out_valid_reg;
    logic       out_acc_reg;
    logic [5:0] out_slot_reg;
    logic [7:0] out_count_reg;

    // Memory ports.
    logic [31:0] xc_q;
    logic [15:0] y_q;
    logic [47:0] scr_q;
    logic        main_wr_xc;
    logic        main_wr_y;
    logic [AW-1:0] main_addr;
    logic [31:0] main_xc_data;
    logic [15:0] main_y_data;
    logic        scr_wr;

    // Insert decision.
    logic [AW-1:0] nxt_slot;
    logic [AW-1:0] start_pos;
    logic [CW-1:0] walk_len;
    logic [7:0]    cap;
    logic          ins_wr_xc;
    logic          ins_wr_y;
    logic [AW-1:0] ins_addr;
    logic [15:0]   ins_code;
    logic [7:0]    count_bumped;
    logic [AW-1:0] cnt_mod_bumped;
    logic          edge_next;
    logic [15:0]   wk_x;
    logic [15:0]   wk_y;
    logic [15:0]   wk_code;
    logic          wk_keep;

    always_comb
    begin
        nxt_slot = (wp_reg == LAST_C) ? '0 : wp_reg + 1'b1;
        if (nxt_slot >= cnt_mod_reg)
        begin
            start_pos = nxt_slot - cnt_mod_reg;
        end
        else
        begin
            start_pos = AW'({1'b0, nxt_slot} + DEPTH_AX - {1'b0, cnt_mod_reg});
        end
        walk_len = (count_reg < DEPTH_B) ? CW'(count_reg) : DEPTH_C;

        count_bumped   = (count_reg == COUNT_MAX) ? count_reg : count_reg + 8'd1;
        cnt_mod_bumped = (count_reg == COUNT_MAX) ? cnt_mod_reg :
                         ((cnt_mod_reg == LAST_C) ? '0 : cnt_mod_reg + 1'b1);

        if ((item_code_reg == CODE_MOVE && !edge_reg) ||
            item_code_reg == CODE_HI_A || item_code_reg == CODE_HI_B)
        begin
            cap = CAP_HIGH;
        end
        else
        begin
            cap = CAP_LOW;
        end

        ins_wr_xc = 1'b0;
        ins_wr_y  = 1'b0;
        ins_addr  = nxt_slot;
        ins_code  = item_code_reg;
        edge_next = edge_reg;
        case (item_kind_reg)
            KIND_WRITE:
            begin
                ins_addr = item_slot_reg[AW-1:0];
                if (item_slot_reg < DEPTH_B)
                begin
                    ins_wr_xc = 1'b1;
                    ins_wr_y  = 1'b1;
                end
            end
            KIND_QUEUE:
            begin
                // The edge is one-shot: every queued event clears it, and only
                // a refused edge code sets it again.
                edge_next = (count_reg >= cap) && (item_code_reg == CODE_EDGE);
                if (count_reg < cap)
                begin
                    ins_wr_xc = 1'b1;
                    ins_wr_y  = 1'b1;
                end
            end
            KIND_KEY:
            begin
                ins_code = CODE_KEY;
                if (count_reg < CAP_LOW)
                begin
                    ins_wr_xc = 1'b1;
                end
            end
            default:
            begin
                ins_wr_xc = 1'b0;
            end
        endcase

        // Entry read during the walk; a never-written entry reads as zero.
        wk_x    = vld_xc_q_reg ? xc_q[31:16] : 16'd0;
        wk_code = vld_xc_q_reg ? xc_q[15:0] : 16'd0;
        wk_y    = vld_y_q_reg ? y_q : 16'd0;
        wk_keep = (wk_code == CODE_MOVE) || (wk_code == CODE_HI_A) ||
                  (wk_code == CODE_HI_B);
        scr_wr  = walk_pend_reg && wk_keep;

        main_wr_xc   = (cmd.exec_op && ins_wr_xc) || copy_pend_reg;
        main_wr_y    = (cmd.exec_op && ins_wr_y) || copy_pend_reg;
        main_addr    = copy_pend_reg ? copy_addr_reg : ins_addr;
        main_xc_data = copy_pend_reg ? {scr_q[47:32], scr_q[15:0]} : {item_x_reg, ins_code};
        main_y_data  = copy_pend_reg ? scr_q[31:16] : item_y_reg;
    end

    assign stat.item_flush = (item_kind_reg == KIND_FLUSH);
    assign stat.out_free   = !out_valid_reg || results.ready;
    assign stat.walk_done  = (walk_i_reg == walk_len);
    assign stat.copy_done  = (copy_j_reg == kept_reg);

    assign results.valid       = out_valid_reg;
    assign results.accepted    = out_acc_reg;
    assign results.stored_slot = out_slot_reg;
    assign results.entry_count = out_count_reg;

    ievr_ram #(.WIDTH(32), .DEPTH(QUEUE_DEPTH)) u_ram_xc (
        .clk     (clk),
        .wr_en   (main_wr_xc),
        .wr_addr (main_addr),
        .wr_data (main_xc_data),
        .rd_en   (cmd.walk_step),
        .rd_addr (walk_pos_reg),
        .rd_data (xc_q)
    );

    ievr_ram #(.WIDTH(16), .DEPTH(QUEUE_DEPTH)) u_ram_y (
        .clk     (clk),
        .wr_en   (main_wr_y),
        .wr_addr (main_addr),
        .wr_data (main_y_data),
        .rd_en   (cmd.walk_step),
        .rd_addr (walk_pos_reg),
        .rd_data (y_q)
    );

    ievr_ram #(.WIDTH(48), .DEPTH(QUEUE_DEPTH)) u_ram_scr (
        .clk     (clk),
        .wr_en   (scr_wr),
        .wr_addr (kept_reg[AW-1:0]),
        .wr_data ({wk_x, wk_y, wk_code}),
        .rd_en   (cmd.copy_step),
        .rd_addr (copy_j_reg[AW-1:0]),
        .rd_data (scr_q)
    );

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg        <= '0;
            count_reg     <= '0;
            cnt_mod_reg   <= '0;
            edge_reg      <= 1'b0;
            vld_xc_reg    <= '0;
            vld_y_reg     <= '0;
            walk_pos_reg  <= '0;
            walk_i_reg    <= '0;
            kept_reg      <= '0;
            copy_j_reg    <= '0;
            walk_pend_reg <= 1'b0;
            copy_pend_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            walk_pend_reg <= cmd.walk_step;
            copy_pend_reg <= cmd.copy_step;

            if (main_wr_xc)
            begin
                vld_xc_reg[main_addr] <= 1'b1;
            end
            if (main_wr_y)
            begin
                vld_y_reg[main_addr] <= 1'b1;
            end

            if (cmd.exec_op)
            begin
                edge_reg <= edge_next;
                if (ins_wr_xc)
                begin
                    wp_reg      <= ins_addr;
                    count_reg   <= count_bumped;
                    cnt_mod_reg <= cnt_mod_bumped;
                end
            end

            if (cmd.flush_init)
            begin
                walk_pos_reg <= start_pos;
                walk_i_reg   <= '0;
                kept_reg     <= '0;
                copy_j_reg   <= '0;
            end

            if (cmd.walk_step)
            begin
                walk_pos_reg <= (walk_pos_reg == LAST_C) ? '0 : walk_pos_reg + 1'b1;
                walk_i_reg   <= walk_i_reg + 1'b1;
            end

            if (scr_wr)
            begin
                kept_reg <= kept_reg + 1'b1;
            end

            if (cmd.copy_step)
            begin
                copy_j_reg <= copy_j_reg + 1'b1;
            end

            if (cmd.flush_finish)
            begin
                wp_reg      <= (kept_reg == '0) ? '0 : AW'(kept_reg - 1'b1);
                count_reg   <= 8'(kept_reg);
                cnt_mod_reg <= (kept_reg == DEPTH_C) ? '0 : kept_reg[AW-1:0];
            end

            if (cmd.exec_op || cmd.flush_finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_kind_reg <= kind_t'(kind);
            item_slot_reg <= slot_index;
            item_x_reg    <= x_value;
            item_y_reg    <= y_value;
            item_code_reg <= event_code;
        end
        if (cmd.walk_step)
        begin
            vld_xc_q_reg <= vld_xc_reg[walk_pos_reg];
            vld_y_q_reg  <= vld_y_reg[walk_pos_reg];
        end
        if (cmd.copy_step)
        begin
            copy_addr_reg <= copy_j_reg[AW-1:0];
        end
        if (cmd.exec_op)
        begin
            out_acc_reg   <= ins_wr_xc;
            out_slot_reg  <= ins_wr_xc ? 6'(ins_addr) : 6'd0;
            out_count_reg <= ins_wr_xc ? count_bumped : count_reg;
        end
        else if (cmd.flush_finish)
        begin
            out_acc_reg   <= 1'b0;
            out_slot_reg  <= 6'd0;
            out_count_reg <= 8'(kept_reg);
        end
    end

    // The write position always names a slot of the ring.
    a_wp_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, wp_reg} < DEPTH_AX)
        else $error("write position beyond ring depth");

    // The count residue tracks the count while the count is below the depth.
    a_cnt_mod_track: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg < DEPTH_B) |-> ({1'b0, cnt_mod_reg} == count_reg[AW:0]))
        else $error("count residue out of step with entry count");

    // The walk never keeps more entries than it has read.
    a_kept_le_walk: assert property (@(posedge clk) disable iff (!rst_n)
        kept_reg <= walk_i_reg)
        else $error("kept entries exceed walked entries");

    // A copy step only reads a scratch slot that the walk filled.
    a_copy_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.copy_step |-> (copy_j_reg < kept_reg))
        else $error("copy step beyond kept entries");

endmodule

`default_nettype wire

// ===== rtl/core/input_event_ring_with_filtered_flush_top.sv =====
// Top level of the input event ring with filtered flush.
// Depends on ievr_pkg, ievr_if, ievr_ram, ievr_ctrl and ievr_dp.
//
// This block keeps a ring of QUEUE_DEPTH input events (x, y and a code) with a
// write position, a saturating entry count and a one-shot edge flag, and returns
// exactly one result word for every event word it takes. A direct write, a queued
// event and a queued key event are each captured in the cycle the word is
// accepted and executed once the result register is free, where the word writes
// the ring memory and loads the result register. A flush visits as many entries
// as the smaller of the entry count and QUEUE_DEPTH and keeps those that survive
// the filter: the walk reads one ring entry per cycle through the single read port
// of the ring memory, and the survivors are then copied back from a scratch buffer
// one per cycle, since compaction in place would overwrite entries that the walk
// has not reached yet. One word is worked on at a time; the next word is taken as
// soon as the previous one is finished, even while its result word still waits in
// the output register. The ring is cleared at reset through per-slot valid bits,
// so there is no clearing pass and the block is ready as soon as reset is released.
`default_nettype none

module input_event_ring_with_filtered_flush_top
    import ievr_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEPTH_DEFAULT
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    ievr_in_if.sink     events,
    ievr_out_if.source  results
);

    ctl_cmd_t  cmd;
    ctl_stat_t stat;
    logic      in_ready;

    // The controller owns the input handshake; the datapath owns the result word.
    assign events.ready = in_ready;

    ievr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (events.valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ievr_dp #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .kind       (events.kind),
        .slot_index (events.slot_index),
        .x_value    (events.x_value),
        .y_value    (events.y_value),
        .event_code (events.event_code),
        .results    (results)
    );

endmodule

`default_nettype wire

// ===== tb/input_event_ring_with_filtered_flush_top_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for input_event_ring_with_filtered_flush_top.
// Depends on ievr_pkg, the ievr_in_if / ievr_out_if interfaces and the block's RTL.

module input_event_ring_with_filtered_flush_top_test;
    import ievr_pkg::*;

    // The ring is built at its default depth, and the shadow ring mirrors that depth.
    localparam int QD             = DEPTH_DEFAULT;
    localparam int QAW            = $clog2(QD);
    // A flush walks and copies at most 2 * QD entries, and each side may also idle
    // at random. The long receiver hold is the worst case, and the limit is set well
    // above it.
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    // The settling time at the end covers one full-depth flush with a wide margin.
    localparam int TAIL_CYCLES    = 60;
    localparam int IDLE_MAX       = 17;

    // One result word as the ring should return it.
    typedef struct {
        logic       accepted;
        logic [5:0] stored_slot;
        logic [7:0] entry_count;
    } ring_result_t;

    logic clk;
    logic rst_n;

    ievr_in_if  ev_ch ();
    ievr_out_if res_ch ();

    input_event_ring_with_filtered_flush_top #(
        .QUEUE_DEPTH(QD)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .events  (ev_ch),
        .results (res_ch)
    );

    // This is a shadow copy of the ring state. It is updated when an event word is
    // accepted, so it always reflects the block's state after that word.
    logic [15:0] shadow_x    [QD];
    logic [15:0] shadow_y    [QD];
    logic [15:0] shadow_code [QD];
    logic [5:0]  shadow_wpos;
    logic [7:0]  shadow_count;
    logic        shadow_edge;

    // This queue holds the result words that are still owed by the block, oldest first.
    ring_result_t pending_results [$];

    int error_count;
    bit tx_idle_on;
    bit rx_idle_on;
    // The backpressure test sets this value. The receiver process then counts it down.
    int hold_request;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    function automatic void bump_shadow_count();
        if (shadow_count != COUNT_MAX)
            shadow_count = shadow_count + 8'd1;
    endfunction

    // This function applies one operation to the shadow ring and returns the
    // result word that the operation should produce.
    function automatic ring_result_t predict_ring_op(kind_t op, logic [7:0] slot,
                                                     logic [15:0] xv, logic [15:0] yv,
                                                     logic [15:0] code);
        ring_result_t r;
        int          cap;
        int          nxt;
        int          start;
        int          walk;
        int          kept;
        int          pos;
        logic [15:0] kx [QD];
        logic [15:0] ky [QD];
        logic [15:0] kc [QD];

        r.accepted    = 1'b0;
        r.stored_slot = '0;
        nxt = (int'(shadow_wpos) + 1) % QD;

        case (op)
            KIND_WRITE:
            begin
                // A slot outside the ring is ignored, and the count does not move.
                if (int'(slot) < QD)
                begin
                    shadow_wpos                = slot[5:0];
                    shadow_x[slot[QAW-1:0]]    = xv;
                    shadow_y[slot[QAW-1:0]]    = yv;
                    shadow_code[slot[QAW-1:0]] = code;
                    bump_shadow_count();
                    r.accepted    = 1'b1;
                    r.stored_slot = slot[5:0];
                end
            end
            KIND_QUEUE:
            begin
                // Codes 0x40 and 0x60 get the high capacity. So does code 0x04,
                // but only while the one-shot edge is clear.
                cap = int'(CAP_LOW);
                if ((code == CODE_MOVE && !shadow_edge) || code == CODE_HI_A ||
                    code == CODE_HI_B)
                    cap = int'(CAP_HIGH);
                shadow_edge = 1'b0;
                if (cap <= int'(shadow_count))
                begin
                    if (code == CODE_EDGE)
                        shadow_edge = 1'b1;
                end
                else
                begin
                    shadow_x[nxt]    = xv;
                    shadow_y[nxt]    = yv;
                    shadow_code[nxt] = code;
                    shadow_wpos      = nxt[5:0];
                    bump_shadow_count();
                    r.accepted    = 1'b1;
                    r.stored_slot = nxt[5:0];
                end
            end
            KIND_KEY:
            begin
                // A key event keeps the old y of its slot and does not touch the edge.
                if (shadow_count < CAP_LOW)
                begin
                    shadow_x[nxt]    = xv;
                    shadow_code[nxt] = CODE_KEY;
                    shadow_wpos      = nxt[5:0];
                    bump_shadow_count();
                    r.accepted    = 1'b1;
                    r.stored_slot = nxt[5:0];
                end
            end
            default:
            begin
                // The flush walks the entries from oldest to newest. It wraps at the
                // ring depth and never visits more than QD entries, even when the
                // count is above the depth.
                start = (int'(shadow_wpos) + 1 + QD - (int'(shadow_count) % QD)) % QD;
                walk  = (int'(shadow_count) < QD) ? int'(shadow_count) : QD;
                kept  = 0;
                for (int i = 0; i < walk; i++)
                begin
                    pos = (start + i) % QD;
                    if (shadow_code[pos] == CODE_MOVE || shadow_code[pos] == CODE_HI_A ||
                        shadow_code[pos] == CODE_HI_B)
                    begin
                        kx[kept] = shadow_x[pos];
                        ky[kept] = shadow_y[pos];
                        kc[kept] = shadow_code[pos];
                        kept++;
                    end
                end
                for (int i = 0; i < kept; i++)
                begin
                    shadow_x[i]    = kx[i];
                    shadow_y[i]    = ky[i];
                    shadow_code[i] = kc[i];
                end
                shadow_wpos  = (kept > 0) ? 6'(kept - 1) : 6'd0;
                shadow_count = 8'(kept);
            end
        endcase

        r.entry_count = shadow_count;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Driving and checking
    // ------------------------------------------------------------------

    // This task offers one event word after an optional random gap. It returns
    // once the word has been accepted. Valid stays high afterward, so that
    // back-to-back words never lower it and raise it again in the same step.
    task automatic send_event(kind_t op, logic [7:0] slot, logic [15:0] xv,
                              logic [15:0] yv, logic [15:0] code);
        int gap;

        gap = tx_idle_on ? $urandom_range(0, IDLE_MAX) : 0;
        if (gap > 0)
        begin
            ev_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        ev_ch.valid      <= 1'b1;
        ev_ch.kind       <= op;
        ev_ch.slot_index <= slot;
        ev_ch.x_value    <= xv;
        ev_ch.y_value    <= yv;
        ev_ch.event_code <= code;
        do
            @(posedge clk);
        while (!ev_ch.ready);
        pending_results.push_back(predict_ring_op(op, slot, xv, yv, code));
    endtask

    // This task stops offering words and waits until every owed result word has arrived.
    task automatic wait_for_results();
        ev_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
        $display("ERROR at %0t: %s: got %0h, expected %0h", $time, what, got, want);
        error_count++;
    endtask

    // Most codes come from the values that the ring treats specially. The rest are
    // near misses and fully random patterns.
    function automatic logic [15:0] pick_code();
        int r;

        r = $urandom_range(0, 99);
        if (r < 12)
            return CODE_MOVE;
        else if (r < 22)
            return CODE_HI_A;
        else if (r < 32)
            return CODE_HI_B;
        else if (r < 47)
            return CODE_EDGE;
        else if (r < 55)
            return CODE_KEY;
        else if (r < 62)
            return CODE_MOVE ^ (16'h0001 << $urandom_range(0, 15));
        return 16'($urandom);
    endfunction

    // This is the result receiver. It checks each accepted result word against the
    // oldest expectation. While its idle pattern is on, it stalls at random after every
    // word. It can also hold ready low for a long stretch, counted here cycle by cycle.
    initial
    begin : result_sink
        int           stall_left;
        int           hold_left;
        ring_result_t want;

        stall_left = 0;
        hold_left  = 0;
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
            begin
                if (pending_results.size() == 0)
                    report_mismatch("result word with nothing expected",
                                    16'(res_ch.entry_count), 16'h0);
                else
                begin
                    want = pending_results.pop_front();
                    if (res_ch.accepted !== want.accepted)
                        report_mismatch("accepted", 16'(res_ch.accepted),
                                        16'(want.accepted));
                    if (res_ch.stored_slot !== want.stored_slot)
                        report_mismatch("stored_slot", 16'(res_ch.stored_slot),
                                        16'(want.stored_slot));
                    if (res_ch.entry_count !== want.entry_count)
                        report_mismatch("entry_count", 16'(res_ch.entry_count),
                                        16'(want.entry_count));
                end
                stall_left = rx_idle_on ? $urandom_range(0, IDLE_MAX) : 0;
            end
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                res_ch.ready <= 1'b0;
            end
            else
                res_ch.ready <= 1'b1;
        end
    end

    // The watchdog ends the run when no word moves on either channel for too long.
    initial
    begin : watchdog
        int idle_cycles;

        idle_cycles = 0;
        @(posedge rst_n);
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((ev_ch.valid === 1'b1 && ev_ch.ready === 1'b1) ||
                (res_ch.valid === 1'b1 && res_ch.ready === 1'b1))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("ERROR: no word moved for %0d cycles", WATCHDOG_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // This test covers every operation, the extremes of the data fields, slots
    // outside the ring, and a flush of an empty ring.
    task automatic test_directed_ops();
        send_event(KIND_FLUSH, 8'd0, 16'h0000, 16'h0000, 16'h0000);
        send_event(KIND_WRITE, 8'd0, 16'h8000, 16'h7FFF, 16'hFFFF);
        send_event(KIND_WRITE, 8'(QD - 1), 16'h7FFF, 16'h8000, CODE_HI_B);
        send_event(KIND_WRITE, 8'(QD), 16'h1234, 16'h5678, CODE_MOVE);
        send_event(KIND_WRITE, 8'hFF, 16'hFFFF, 16'hFFFF, CODE_HI_A);
        send_event(KIND_QUEUE, 8'hFF, 16'hFFFF, 16'h0000, CODE_MOVE);
        send_event(KIND_KEY, 8'h00, 16'hFFFF, 16'h7FFF, 16'hFFFF);
        send_event(KIND_QUEUE, 8'h00, 16'h0001, 16'hFFFF, 16'h8000);
        send_event(KIND_FLUSH, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    endtask

    // This test fills the ring to seven entries. It then lets a refused code 0x02
    // arm the edge, and shows that a key event leaves the edge alone. The next
    // code 0x04 then meets the low capacity, and the one after it meets the high
    // capacity again.
    task automatic test_edge_flag();
        while (shadow_count < CAP_LOW)
            send_event(KIND_QUEUE, 8'd3, 16'($urandom), 16'($urandom), CODE_HI_A);
        send_event(KIND_QUEUE, 8'd0, 16'h0102, 16'h0304, CODE_EDGE);
        send_event(KIND_KEY, 8'd0, 16'h0042, 16'h0000, 16'h0000);
        send_event(KIND_QUEUE, 8'd0, 16'h1111, 16'h2222, CODE_MOVE);
        send_event(KIND_QUEUE, 8'd0, 16'h3333, 16'h4444, CODE_MOVE);
        send_event(KIND_QUEUE, 8'd0, 16'h5555, 16'h6666, CODE_HI_B);
        send_event(KIND_QUEUE, 8'd0, 16'h7777, 16'h8888, CODE_HI_A);
        send_event(KIND_FLUSH, 8'd0, 16'h0000, 16'h0000, 16'h0000);
    endtask

    // Direct writes have no capacity check. This test pushes the count to its
    // ceiling, then shows that both queued operations are refused there. It ends
    // with a flush that walks a count above the ring depth.
    task automatic test_count_saturation();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b1;
        repeat (270)
            send_event(KIND_WRITE, 8'($urandom_range(0, QD - 1)), 16'($urandom),
                       16'($urandom), pick_code());
        send_event(KIND_QUEUE, 8'd0, 16'($urandom), 16'($urandom), CODE_HI_A);
        send_event(KIND_KEY, 8'd0, 16'($urandom), 16'($urandom), 16'($urandom));
        send_event(KIND_FLUSH, 8'd0, 16'($urandom), 16'($urandom), 16'($urandom));
    endtask

    // The receiver holds ready low for a long stretch while words keep coming, so
    // the output register fills and the block must stall its input. Afterward the
    // sender pauses until every owed word has arrived.
    task automatic test_backpressure();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        wait_for_results();
        hold_request = HOLD_CYCLES;
        for (int i = 0; i < 10; i++)
            send_event(kind_t'(i % 4), 8'($urandom_range(0, QD - 1)), 16'($urandom),
                       16'($urandom), pick_code());
        wait_for_results();
    endtask

    // The random traffic mixes queued events, key events, flushes and direct writes
    // that sometimes miss the ring, and flushes come more often once the count
    // reaches the low capacity. Fully random words are mixed in. The idle pattern
    // of each side changes every few dozen words, and the sender stops now and
    // then until the ring has answered everything.
    task automatic test_random_traffic();
        int r;

        for (int i = 0; i < 850; i++)
        begin
            if (i % 60 == 0)
            begin
                tx_idle_on = 1'($urandom_range(0, 1));
                rx_idle_on = 1'($urandom_range(0, 1));
            end
            if (i % 170 == 169)
                wait_for_results();
            r = $urandom_range(0, 99);
            if (r < 6 || (shadow_count >= CAP_LOW && r < 20))
                send_event(KIND_FLUSH, 8'($urandom), 16'($urandom), 16'($urandom),
                           16'($urandom));
            else if (r < 30)
                send_event(KIND_WRITE,
                           ($urandom_range(0, 3) == 0) ? 8'($urandom) :
                                                         8'($urandom_range(0, QD - 1)),
                           16'($urandom), 16'($urandom), pick_code());
            else if (r < 45)
                send_event(KIND_KEY, 8'($urandom), 16'($urandom), 16'($urandom),
                           16'($urandom));
            else
                send_event(KIND_QUEUE, 8'($urandom), 16'($urandom), 16'($urandom),
                           pick_code());
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        error_count  = 0;
        hold_request = 0;
        tx_idle_on   = 1'b1;
        rx_idle_on   = 1'b1;
        for (int i = 0; i < QD; i++)
        begin
            shadow_x[i]    = '0;
            shadow_y[i]    = '0;
            shadow_code[i] = '0;
        end
        shadow_wpos  = '0;
        shadow_count = '0;
        shadow_edge  = 1'b0;

        rst_n            <= 1'b0;
        ev_ch.valid      <= 1'b0;
        ev_ch.kind       <= KIND_WRITE;
        ev_ch.slot_index <= '0;
        ev_ch.x_value    <= '0;
        ev_ch.y_value    <= '0;
        ev_ch.event_code <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        test_directed_ops();
        test_edge_flag();
        test_count_saturation();
        test_backpressure();
        test_random_traffic();

        // Wait for every owed word. Then allow time for any stray word to show up
        // and be flagged.
        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/ievr_pkg.sv
rtl/core/ievr_if.sv
rtl/core/ievr_ram.sv
rtl/core/ievr_ctrl.sv
rtl/core/ievr_dp.sv
rtl/core/input_event_ring_with_filtered_flush_top.sv
tb/input_event_ring_with_filtered_flush_top_test.sv
